>>> src/aesa_nearest_neighbour_search_assert.svh
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef AESA_NEAREST_NEIGHBOUR_SEARCH_ASSERT_SVH
`define AESA_NEAREST_NEIGHBOUR_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define AESA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AESA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/aesa_pkg.sv
package aesa_pkg;

  localparam int MAX_PROTO = 64;
  localparam int IDX_W     = 6;
  localparam int DIST_W    = 32;
  localparam int STEP_W    = 7;
  localparam int CNT_W     = 7;
  localparam int TAB_AW    = 2 * IDX_W;
  localparam int IN_DW     = 48;
  localparam int OUT_DW    = 56;

  localparam logic [CNT_W-1:0] PC_RESET = CNT_W'(MAX_PROTO);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_REPLY = 2'd2;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic              elim;
    logic [DIST_W-1:0] lb;
  } bound_wr_t;

endpackage

>>> src/aesa_table_ram.sv
module aesa_table_ram (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [aesa_pkg::TAB_AW-1:0]     wr_addr_i,
  input  logic [aesa_pkg::DIST_W-1:0]     wr_data_i,
  input  logic [aesa_pkg::TAB_AW-1:0]     rd_addr_i,
  output logic [aesa_pkg::DIST_W-1:0]     rd_data_o
);

  localparam int DEPTH = 1 << aesa_pkg::TAB_AW;

  logic [aesa_pkg::DIST_W-1:0] mem_q [DEPTH];
  logic [aesa_pkg::DIST_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/aesa_bound_mem.sv
module aesa_bound_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic [aesa_pkg::IDX_W-1:0]    rd_addr_i,
  output logic [aesa_pkg::DIST_W:0]     rd_data_o,
  input  aesa_pkg::bound_wr_t           wr_i
);

  // word = {eliminated, lower bound}; an entry without its valid bit reads as zero
  logic [aesa_pkg::DIST_W:0]        mem_q [aesa_pkg::MAX_PROTO];
  logic [aesa_pkg::MAX_PROTO-1:0]   valid_q;
  logic [aesa_pkg::DIST_W:0]        rd_raw_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.elim, wr_i.lb};
    end
    rd_raw_q <= mem_q[rd_addr_i];
    rd_vld_q <= valid_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> src/aesa_nearest_neighbour_search.sv
// Channel   Dir  Accept on                    Payload
// s_axis    in   s_axis_tvalid & tready       tuser: cmd; tdata: row, col, value
// m_axis    out  m_axis_tvalid & tready       tuser: kind; tdata: pivot, nearest,
//                                             best_distance, step_of_nearest
// cfg       in   cfg_valid & cfg_ready        cfg_data: prototype_count
//
// Table writes, starts and ignored commands leave the block idle.
// A distance reply sweeps all 64 bound entries, one per cycle, through a
// three-stage read/compute/write-back pipe before the result is registered.
// Reset clears the bound valid bits at once; the distance table is not cleared.
// Input is taken only while idle and the output register is free or draining.
module aesa_nearest_neighbour_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [aesa_pkg::IN_DW-1:0]    s_axis_tdata,   // row[5:0], col[11:6], value[43:12]
  input  logic [1:0]                    s_axis_tuser,   // cmd[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [aesa_pkg::OUT_DW-1:0]   m_axis_tdata,   // pivot[5:0], nearest[11:6],
                                                        // best_distance[43:12], step[50:44]
  output logic                          m_axis_tuser,   // kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aesa_pkg::CNT_W-1:0]    cfg_data
);

  localparam int IW = aesa_pkg::IDX_W;
  localparam int DW = aesa_pkg::DIST_W;
  localparam int CW = aesa_pkg::CNT_W;
  localparam int SW = aesa_pkg::STEP_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic            state_q;
  logic            searching_q;
  logic [CW-1:0]   pc_q;
  logic [CW-1:0]   n_q;
  logic [CW-1:0]   n_d;
  logic [IW-1:0]   piv_q;
  logic [DW-1:0]   val_q;
  logic [SW-1:0]   step_q;
  logic [SW-1:0]   step_d;
  logic [DW-1:0]   best_q;
  logic [IW-1:0]   bidx_q;
  logic [SW-1:0]   bstep_q;

  logic [CW-1:0]   iss_q;
  logic            iss_go;
  logic            s1_vld_q;
  logic [IW-1:0]   idx1_q;
  logic            s2_vld_q;
  logic [IW-1:0]   idx2_q;
  logic [DW-1:0]   d2_q;
  logic [DW:0]     lbw_q;

  logic            found_q;
  logic [DW-1:0]   least_q;
  logic [IW-1:0]   pick_q;

  logic            out_vld_q;
  logic            out_kind_q;
  logic [IW-1:0]   out_piv_q;
  logic [IW-1:0]   out_near_q;
  logic [DW-1:0]   out_dist_q;
  logic [SW-1:0]   out_step_q;

  logic [1:0]      in_cmd;
  logic [IW-1:0]   in_row;
  logic [IW-1:0]   in_col;
  logic [DW-1:0]   in_val;
  logic            in_acc;
  logic            wr_go;
  logic            start_go;
  logic            rep_go;

  logic [DW-1:0]   tab_rd;
  logic [DW:0]     bnd_rd;
  logic [DW:0]     diff_tv;
  logic [DW-1:0]   diff_vt;
  logic [DW-1:0]   absd;

  logic            in_rng;
  logic [DW-1:0]   lb_old;
  logic            el_old;
  logic [DW-1:0]   lb_new;
  logic            el_new;
  logic            take;
  logic            found_d;
  logic [DW-1:0]   least_d;
  logic [IW-1:0]   pick_d;
  logic            s2_last;

  aesa_pkg::bound_wr_t bnd_wr;

  assign in_cmd = s_axis_tuser;
  assign in_row = s_axis_tdata[IW-1:0];
  assign in_col = s_axis_tdata[2*IW-1:IW];
  assign in_val = s_axis_tdata[2*IW+DW-1:2*IW];

  assign s_axis_tready = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign wr_go    = in_acc && (in_cmd == aesa_pkg::CMD_WRITE);
  assign start_go = in_acc && (in_cmd == aesa_pkg::CMD_START);
  assign rep_go   = in_acc && (in_cmd == aesa_pkg::CMD_REPLY) && searching_q;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (pc_q == '0) begin
      n_d = CW'(1);
    end else if (pc_q > CW'(aesa_pkg::MAX_PROTO)) begin
      n_d = CW'(aesa_pkg::MAX_PROTO);
    end else begin
      n_d = pc_q;
    end
  end

  assign step_d = step_q + SW'(1);
  assign iss_go = (state_q == ST_SWEEP) && (iss_q < CW'(aesa_pkg::MAX_PROTO));

  aesa_table_ram u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_go),
    .wr_addr_i ({in_row, in_col}),
    .wr_data_i (in_val),
    .rd_addr_i ({piv_q, iss_q[IW-1:0]}),
    .rd_data_o (tab_rd)
  );

  aesa_bound_mem u_bound (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (start_go),
    .rd_addr_i (iss_q[IW-1:0]),
    .rd_data_o (bnd_rd),
    .wr_i      (bnd_wr)
  );

  // stage 1: |table - d|
  assign diff_tv = {1'b0, tab_rd} - {1'b0, val_q};
  assign diff_vt = val_q - tab_rd;
  assign absd    = diff_tv[DW] ? diff_vt : diff_tv[DW-1:0];

  // stage 2: raise bound, eliminate, track least bound
  always_comb begin
    lb_old  = lbw_q[DW-1:0];
    el_old  = lbw_q[DW];
    in_rng  = {1'b0, idx2_q} < n_q;
    lb_new  = (in_rng && (d2_q > lb_old)) ? d2_q : lb_old;
    el_new  = el_old || (idx2_q == piv_q) || (in_rng && (lb_new >= best_q));
    take    = s2_vld_q && in_rng && !el_new && (!found_q || (lb_new < least_q));
    found_d = found_q || take;
    least_d = take ? lb_new : least_q;
    pick_d  = take ? idx2_q : pick_q;
    bnd_wr.en   = s2_vld_q;
    bnd_wr.addr = idx2_q;
    bnd_wr.elim = el_new;
    bnd_wr.lb   = lb_new;
  end

  assign s2_last = s2_vld_q && (idx2_q == IW'(aesa_pkg::MAX_PROTO - 1));

  always_ff @(posedge clk_i) begin
    d2_q   <= absd;
    lbw_q  <= bnd_rd;
    idx1_q <= iss_q[IW-1:0];
    idx2_q <= idx1_q;
    least_q <= least_d;
    pick_q  <= pick_d;
    if (rep_go) begin
      val_q <= in_val;
      n_q   <= n_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      searching_q <= 1'b0;
      pc_q        <= aesa_pkg::PC_RESET;
      piv_q       <= '0;
      step_q      <= '0;
      best_q      <= '1;
      bidx_q      <= '0;
      bstep_q     <= '0;
      iss_q       <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      s1_vld_q <= iss_go;
      s2_vld_q <= s1_vld_q;
      found_q  <= rep_go ? 1'b0 : found_d;
      if (cfg_valid) begin
        pc_q <= cfg_data;
      end
      if (iss_go) begin
        iss_q <= iss_q + CW'(1);
      end
      if (start_go) begin
        searching_q <= 1'b1;
        piv_q       <= '0;
        step_q      <= '0;
        best_q      <= '1;
        bidx_q      <= '0;
        bstep_q     <= '0;
      end
      if (rep_go) begin
        state_q <= ST_SWEEP;
        step_q  <= step_d;
        iss_q   <= '0;
        if (in_val < best_q) begin
          best_q  <= in_val;
          bidx_q  <= piv_q;
          bstep_q <= step_d;
        end
      end
      if (s2_last) begin
        state_q <= ST_IDLE;
        if (found_d) begin
          piv_q <= pick_d;
        end else begin
          piv_q       <= '0;
          searching_q <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (start_go || s2_last) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_go) begin
      out_kind_q <= aesa_pkg::KIND_REQUEST;
      out_piv_q  <= '0;
      out_near_q <= '0;
      out_dist_q <= '0;
      out_step_q <= '0;
    end else if (s2_last) begin
      if (found_d) begin
        out_kind_q <= aesa_pkg::KIND_REQUEST;
        out_piv_q  <= pick_d;
        out_near_q <= '0;
        out_dist_q <= '0;
        out_step_q <= '0;
      end else begin
        out_kind_q <= aesa_pkg::KIND_DONE;
        out_piv_q  <= '0;
        out_near_q <= bidx_q;
        out_dist_q <= best_q;
        out_step_q <= bstep_q;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {(aesa_pkg::OUT_DW - (2*IW + DW + SW))'(0),
                          out_step_q, out_dist_q, out_near_q, out_piv_q};

`include "aesa_nearest_neighbour_search_assert.svh"

  `AESA_ASSERT_IMP(a_out_free, s2_last, !out_vld_q, "result slot busy at sweep end")
  `AESA_ASSERT_IMP(a_no_accept_sweep, state_q == ST_SWEEP, !s_axis_tready, "input ready in sweep")
  `AESA_ASSERT_IMP(a_pipe_in_sweep, s2_vld_q, state_q == ST_SWEEP, "pipe active outside sweep")
  `AESA_ASSERT_NXT(a_done_report, s2_last && !found_d,
                   !searching_q && out_vld_q && (out_kind_q == aesa_pkg::KIND_DONE),
                   "finished search not reported")

endmodule
